/* rtl/core/morse_character_keyer_unit_defines.svh */
// ----------------------------------------------------------------------------
// morse character keyer assertion macros
// shared property shapes for the checker, clocked on aclk, off in reset
// ----------------------------------------------------------------------------
`ifndef MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH

// same-cycle implication
`define MCK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("keyer check failed (same cycle)");

// next-cycle implication
`define MCK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("keyer check failed (next cycle)");

`endif

/* rtl/core/mck_pkg.sv */
// ----------------------------------------------------------------------------
// mck_pkg
// types, constants and the element rom for the morse character keyer
// ----------------------------------------------------------------------------
`default_nettype none

package mck_pkg;

    localparam int CHAR_W     = 8;
    localparam int UNIT_W     = 21;
    localparam int PAT_W      = 30;
    localparam int LEN_W      = 5;
    localparam int LEAD_UNITS = 1;
    localparam int TRAIL_UNITS = 6;
    localparam int SH_W       = LEAD_UNITS + PAT_W + TRAIL_UNITS;
    localparam int CNT_W      = 6;
    localparam int ROM_IDX_W  = 6;
    localparam int MAX_ELEM   = 6;

    localparam logic [CHAR_W-1:0] LOWER_A     = 8'd97;
    localparam logic [CHAR_W-1:0] LOWER_Z     = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [CHAR_W-1:0] TABLE_BASE  = 8'd32;
    localparam logic [CHAR_W-1:0] FALLBACK_IDX = 8'd31;

    localparam logic [UNIT_W-1:0] UNIT_RESET   = 21'd60000;
    localparam logic [UNIT_W-1:0] ON_DUR_RESET = 21'd90000;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;   // left aligned, first unit in the msb
    } rom_word_t;

    // element pattern of one table entry: count, dash mask (first element
    // in bit n-1), and the number of trailing word gaps of three off units
    function automatic rom_word_t rom_entry(input logic [ROM_IDX_W-1:0] idx);
        logic [2:0]       n;
        logic [5:0]       dm;
        logic [1:0]       gap;
        logic [PAT_W-1:0] p;
        logic [LEN_W-1:0] l;
        rom_word_t        w;
        n   = 3'd0;
        dm  = 6'b000000;
        gap = 2'd0;
        case (idx)
            6'd0:  begin n = 3'd0; gap = 2'd2; end
            6'd1:  begin n = 3'd6; dm = 6'b101011; end
            6'd11: begin n = 3'd5; dm = 6'b001010; end
            6'd12: begin n = 3'd6; dm = 6'b110011; end
            6'd13: begin n = 3'd6; dm = 6'b100001; end
            6'd14: begin n = 3'd6; dm = 6'b010101; end
            6'd15: begin n = 3'd5; dm = 6'b010010; end
            6'd16: begin n = 3'd5; dm = 6'b011111; end
            6'd17: begin n = 3'd5; dm = 6'b001111; end
            6'd18: begin n = 3'd5; dm = 6'b000111; end
            6'd19: begin n = 3'd5; dm = 6'b000011; end
            6'd20: begin n = 3'd5; dm = 6'b000001; end
            6'd21: begin n = 3'd5; dm = 6'b000000; end
            6'd22: begin n = 3'd5; dm = 6'b010000; end
            6'd23: begin n = 3'd5; dm = 6'b011000; end
            6'd24: begin n = 3'd5; dm = 6'b011100; end
            6'd25: begin n = 3'd5; dm = 6'b011110; end
            6'd26: begin n = 3'd6; dm = 6'b111000; gap = 2'd1; end
            6'd27: begin n = 3'd6; dm = 6'b101010; end
            6'd29: begin n = 3'd5; dm = 6'b010001; end
            6'd31: begin n = 3'd6; dm = 6'b001100; end
            6'd33: begin n = 3'd2; dm = 6'b000001; end
            6'd34: begin n = 3'd4; dm = 6'b001000; end
            6'd35: begin n = 3'd4; dm = 6'b001010; end
            6'd36: begin n = 3'd3; dm = 6'b000100; end
            6'd37: begin n = 3'd1; dm = 6'b000000; end
            6'd38: begin n = 3'd4; dm = 6'b000010; end
            6'd39: begin n = 3'd3; dm = 6'b000110; end
            6'd40: begin n = 3'd4; dm = 6'b000000; end
            6'd41: begin n = 3'd2; dm = 6'b000000; end
            6'd42: begin n = 3'd4; dm = 6'b000111; end
            6'd43: begin n = 3'd3; dm = 6'b000101; end
            6'd44: begin n = 3'd4; dm = 6'b000100; end
            6'd45: begin n = 3'd2; dm = 6'b000011; end
            6'd46: begin n = 3'd2; dm = 6'b000010; end
            6'd47: begin n = 3'd3; dm = 6'b000111; end
            6'd48: begin n = 3'd4; dm = 6'b000110; end
            6'd49: begin n = 3'd4; dm = 6'b001101; end
            6'd50: begin n = 3'd3; dm = 6'b000010; end
            6'd51: begin n = 3'd3; dm = 6'b000000; end
            6'd52: begin n = 3'd1; dm = 6'b000001; end
            6'd53: begin n = 3'd3; dm = 6'b000001; end
            6'd54: begin n = 3'd4; dm = 6'b000001; end
            6'd55: begin n = 3'd3; dm = 6'b000011; end
            6'd56: begin n = 3'd4; dm = 6'b001001; end
            6'd57: begin n = 3'd4; dm = 6'b001011; end
            6'd58: begin n = 3'd4; dm = 6'b001100; end
            default: begin n = 3'd0; dm = 6'b000000; gap = 2'd0; end
        endcase
        p = '0;
        l = '0;
        for (int i = 0; i < MAX_ELEM; i++) begin
            if (3'(i) < n) begin
                if (i != 0) begin
                    p = p << 3;
                    l = l + 5'd3;
                end
                if (dm[n - 3'd1 - 3'(i)]) begin
                    p = (p << 3) | PAT_W'(3'b111);
                    l = l + 5'd3;
                end else begin
                    p = (p << 1) | PAT_W'(1'b1);
                    l = l + 5'd1;
                end
            end
        end
        l = l + LEN_W'(3 * int'(gap));
        p = p << (3 * int'(gap));
        w.len = l;
        w.pat = p << (LEN_W'(PAT_W) - l);
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/morse_character_keyer_unit.sv */
// ----------------------------------------------------------------------------
// morse_character_keyer_unit
// ascii to morse keying units with on/off level and duration per unit
// ----------------------------------------------------------------------------
// Each accepted character (lower case folded, codes beyond the table sent as '?')
// yields len+7 keying units, one per clock while m_tready is high: a leading
// off unit, the element pattern msb first and six trailing off units, the
// final one marked by m_tlast. A character therefore yields 7 to 37 units,
// shifted out of the output shift register. The element rom is read into its
// register as a character is taken, and the next character is fetched and
// held while the current one is still being keyed, so runs follow each other
// without a gap. Off units last unit_time_us, on units one and a half units,
// saturated to 21 bits; the user must write the unit time over the cfg channel
// only while the block is idle, the block itself does not enforce it.
`default_nettype none

module morse_character_keyer_unit #(
    parameter int TABLE_ENTRIES = 59
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: unit_time_us
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [20:0] cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [0] key_on, [21:1] duration_us, [23:22] zero
    output logic             m_tlast    // last_unit
);

    localparam logic [mck_pkg::CHAR_W-1:0] ENTRIES = mck_pkg::CHAR_W'(TABLE_ENTRIES);

    logic [mck_pkg::UNIT_W-1:0] unit_reg, unit_next;
    logic [mck_pkg::UNIT_W-1:0] on_dur_reg, on_dur_next;
    logic                       rom_vld_reg, rom_vld_next;
    mck_pkg::rom_word_t         rom_q_reg;
    logic [mck_pkg::SH_W-1:0]   sh_reg, sh_next;
    logic [mck_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic [mck_pkg::CHAR_W-1:0] folded;
    logic [mck_pkg::CHAR_W-1:0] idx;
    logic [mck_pkg::UNIT_W:0]   on_sum;
    logic                       s_xfer;
    logic                       busy;
    logic                       load;

    assign cfg_ready = 1'b1;
    assign s_tready  = !rom_vld_reg;
    assign s_xfer    = s_tvalid && s_tready;
    assign busy      = (cnt_reg != '0);
    assign load      = rom_vld_reg && (!busy || (m_tready && cnt_reg == 6'd1));

    // fold case and map onto the table, out of range goes to '?'
    always_comb begin
        folded = s_tdata;
        if (s_tdata >= mck_pkg::LOWER_A && s_tdata <= mck_pkg::LOWER_Z) begin
            folded = s_tdata - mck_pkg::CASE_OFFSET;
        end
        idx = folded - mck_pkg::TABLE_BASE;
        if (idx >= ENTRIES) begin
            idx = mck_pkg::FALLBACK_IDX;
        end
    end

    // on time is one and a half units, saturating
    assign on_sum = {1'b0, cfg_data} + {2'b00, cfg_data[mck_pkg::UNIT_W-1:1]};

    always_comb begin
        unit_next   = unit_reg;
        on_dur_next = on_dur_reg;
        if (cfg_valid && cfg_ready) begin
            unit_next   = cfg_data;
            on_dur_next = on_sum[mck_pkg::UNIT_W] ? '1 : on_sum[mck_pkg::UNIT_W-1:0];
        end
    end

    always_comb begin
        rom_vld_next = rom_vld_reg;
        if (s_xfer) begin
            rom_vld_next = 1'b1;
        end else if (load) begin
            rom_vld_next = 1'b0;
        end
    end

    always_comb begin
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (load) begin
            sh_next  = {1'b0, rom_q_reg.pat, {mck_pkg::TRAIL_UNITS{1'b0}}};
            cnt_next = {1'b0, rom_q_reg.len}
                       + mck_pkg::CNT_W'(mck_pkg::LEAD_UNITS + mck_pkg::TRAIL_UNITS);
        end else if (busy && m_tready) begin
            sh_next  = sh_reg << 1;
            cnt_next = cnt_reg - 6'd1;
        end
    end

    // element rom, synchronous read
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            rom_q_reg <= mck_pkg::rom_entry(idx[mck_pkg::ROM_IDX_W-1:0]);
        end
        sh_reg <= sh_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg    <= mck_pkg::UNIT_RESET;
            on_dur_reg  <= mck_pkg::ON_DUR_RESET;
            rom_vld_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            unit_reg    <= unit_next;
            on_dur_reg  <= on_dur_next;
            rom_vld_reg <= rom_vld_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign m_tvalid = busy;
    assign m_tlast  = (cnt_reg == 6'd1);
    assign m_tdata  = {2'b00,
                       sh_reg[mck_pkg::SH_W-1] ? on_dur_reg : unit_reg,
                       sh_reg[mck_pkg::SH_W-1]};

endmodule

`default_nettype wire

/* rtl/core/mck_checker.sv */
// ----------------------------------------------------------------------------
// mck_checker
// port level checks on the keyer result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "morse_character_keyer_unit_defines.svh"

module mck_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // stalled result holds
    `MCK_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // a run always ends on an off unit
    `MCK_ASSERT_NOW(a_last_off, m_tvalid && m_tlast, !m_tdata[0])

    // units of one run come without a gap
    `MCK_ASSERT_NEXT(a_no_gap, m_tvalid && m_tready && !m_tlast, m_tvalid)

    // a new run opens with its leading off unit
    `MCK_ASSERT_NEXT(a_lead_off, m_tvalid && m_tready && m_tlast, !(m_tvalid && m_tdata[0]))

endmodule

bind morse_character_keyer_unit mck_checker u_mck_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
